@@ rtl/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Entry, command and result structs, status codes and sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int Capacity = 16;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int CountW   = 5;
  localparam int StatusW  = 3;

  localparam logic [StatusW-1:0] StOk    = 3'd0;
  localparam logic [StatusW-1:0] StNull  = 3'd1;
  localparam logic [StatusW-1:0] StDup   = 3'd2;
  localparam logic [StatusW-1:0] StFull  = 3'd3;
  localparam logic [StatusW-1:0] StEmpty = 3'd4;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] item_id;
    logic [7:0]  kind;
    logic [15:0] priority_req;
  } spq_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic [15:0]        out_item_id;
    logic [7:0]         out_kind;
    logic [15:0]        out_priority;
  } spq_res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  kind;
    logic [15:0] pri;
  } spq_entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry, flags whether a new entry belongs at or before it, and
// shifts toward the tail on insert or toward the head on remove.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire             clk_i,
  input  wire spq_ctrl_t  ctrl_i,
  input  wire             occ_i,
  input  wire spq_entry_t new_i,
  input  wire spq_entry_t left_i,
  input  wire             left_sel_i,
  input  wire spq_entry_t right_i,
  output spq_entry_t      ent_o,
  output logic            sel_o,
  output logic            dup_o
);

  spq_entry_t ent_q, ent_d;

  // an empty slot or a strictly larger priority means the new entry goes here or earlier
  assign sel_o = ~occ_i | (ent_q.pri > new_i.pri);
  assign dup_o = occ_i & (ent_q.id == new_i.id);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      if (left_sel_i) begin
        ent_d = left_i;
      end else if (sel_o) begin
        ent_d = new_i;
      end
    end else if (ctrl_i.rem) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

@@ rtl/stable_priority_queue_top.sv @@
// ---------------------------------------------------------------------------
// stable_priority_queue_top: bounded min-priority queue, stable on ties
// Sorted chain of slot cells with a registered result.
// ---------------------------------------------------------------------------
// An item is taken on every clock edge with start high; busy stays low, so
// one insert or remove is accepted per cycle. Its result appears on res_o,
// with done_o high, in the cycle after acceptance: every slot cell
// compares and shifts in the same cycle, and the result register sits at
// the output. The receiver cannot stall, so done_o must be sampled then.
// Inserts place the entry after all entries of lower or equal priority;
// removes return the head. The reported count is the fill after the item.
`default_nettype none

module stable_priority_queue_top
  import spq_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  wire spq_req_t req_i,
  output logic          done_o,
  output spq_res_t      res_o
);

  spq_entry_t            ent   [Capacity];
  logic [Capacity-1:0]   sel;
  logic [Capacity-1:0]   dup;
  logic [Capacity-1:0]   occ;
  spq_entry_t            new_ent;
  spq_ctrl_t             ctrl;
  logic [CntW-1:0]       count_q, count_d;
  logic                  done_q;
  spq_res_t              res_q, res_d;
  logic                  accept, is_dup, is_full, is_empty;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign new_ent.id   = req_i.item_id;
  assign new_ent.kind = req_i.kind;
  assign new_ent.pri  = req_i.priority_req;

  assign is_dup   = |dup;
  assign is_full  = (count_q == CntW'(Capacity));
  assign is_empty = (count_q == '0);

  assign ctrl.ins = accept & (req_i.mode == ModeInsert) & (req_i.item_id != 16'd0)
                  & ~is_dup & ~is_full;
  assign ctrl.rem = accept & (req_i.mode == ModeRemove) & ~is_empty;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign occ[i] = (count_q > CntW'(i));

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[i]),
      .new_i      (new_ent),
      .left_i     ((i == 0) ? new_ent : ent[(i == 0) ? 0 : i - 1]),
      .left_sel_i ((i == 0) ? 1'b0 : sel[(i == 0) ? 0 : i - 1]),
      .right_i    ((i == Capacity - 1) ? ent[i] : ent[(i == Capacity - 1) ? i : i + 1]),
      .ent_o      (ent[i]),
      .sel_o      (sel[i]),
      .dup_o      (dup[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.count        = CountW'(count_d);
    if (req_i.mode == ModeInsert) begin
      if (req_i.item_id == 16'd0) begin
        res_d.status = StNull;
      end else if (is_dup) begin
        res_d.status = StDup;
      end else if (is_full) begin
        res_d.status = StFull;
      end else begin
        res_d.status = StOk;
      end
    end else if (is_empty) begin
      res_d.status = StEmpty;
    end else begin
      res_d.status       = StOk;
      res_d.out_item_id  = ent[0].id;
      res_d.out_kind     = ent[0].kind;
      res_d.out_priority = ent[0].pri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // -------------------------------------------------------------------------
  // assertions

  logic [Capacity-1:0] order_ok;
  assign order_ok[0] = 1'b1;
  for (genvar j = 1; j < Capacity; j++) begin : g_ord
    assign order_ok[j] = ~occ[j] | (ent[j-1].pri <= ent[j].pri);
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("fill count above capacity");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("stored entries out of priority order");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted item gave no result");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == StEmpty) |-> (res_o.count == '0))
    else $error("empty status with nonzero count");

  a_no_double_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove in the same cycle");

endmodule

`default_nettype wire
